>>> hw/rtl/hcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Harris corner detector.
// Depends on nothing; the files that use it refer to it by scoped names.
package hcd_pkg;

   localparam int MaxWidth    = 1024;
   localparam int AddrBits    = 13;
   localparam int HistDepth   = 1 << AddrBits;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 32;
   localparam int RespBits    = 35;

   localparam logic [CsrIdxBits-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CsrIdxBits-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CsrIdxBits-1:0] REG_WEIGHT_CORNER = 3'd2;
   localparam logic [CsrIdxBits-1:0] REG_WEIGHT_EDGE   = 3'd3;
   localparam logic [CsrIdxBits-1:0] REG_WEIGHT_CENTER = 3'd4;
   localparam logic [CsrIdxBits-1:0] REG_HARRIS_K      = 3'd5;
   localparam logic [CsrIdxBits-1:0] REG_THRESHOLD     = 3'd6;

   typedef struct packed {
      logic [15:0]        xx;
      logic [15:0]        yy;
      logic signed [16:0] xy;
   } prod_type;

   typedef struct packed {
      logic [15:0] w_corner;
      logic [15:0] w_edge;
      logic [15:0] w_center;
      logic [15:0] k;
   } coeff_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/hcd_req_if.sv
`timescale 1ns / 1ps
// Request channel of the corner detector: valid, ready, command and pixel.
// No dependencies.
interface hcd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] pixel;

   modport source(output valid, output cmd, output pixel, input ready);
   modport sink(input valid, input cmd, input pixel, output ready);
endinterface

>>> hw/rtl/hcd_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the corner detector: valid, ready and the result fields.
// No dependencies.
interface hcd_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         pixel_out;
   logic               is_corner;
   logic signed [34:0] response;
   logic [9:0]         out_col;
   logic [11:0]        out_row;
   logic               frame_last;

   modport source(output valid, output pixel_out, output is_corner, output response,
                  output out_col, output out_row, output frame_last, input ready);
   modport sink(input valid, input pixel_out, input is_corner, input response,
                input out_col, input out_row, input frame_last, output ready);
endinterface

>>> hw/rtl/hcd_history.sv
`timescale 1ns / 1ps
// Pixel history memory: one write port and one registered read port.
// Uses hcd_pkg for the address width and depth.
module hcd_history (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [hcd_pkg::AddrBits-1:0] wr_addr,
   input  logic [8:0]                   wr_data,
   input  logic [hcd_pkg::AddrBits-1:0] rd_addr,
   output logic [8:0]                   rd_data
);
   logic [8:0] mem_ff [hcd_pkg::HistDepth];
   logic [8:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/hcd_pix_cell.sv
`timescale 1ns / 1ps
// One cell of the pixel window chain: holds a pixel and passes it on.
// No package dependencies.
module hcd_pix_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] d,
   output logic [7:0] q
);
   logic [7:0] pixel_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pixel_ff <= d;
      end
   end

   assign q = pixel_ff;
endmodule

>>> hw/rtl/hcd_prod_cell.sv
`timescale 1ns / 1ps
// One cell of the gradient product chain: holds xx, yy and xy of one position.
// Uses hcd_pkg::prod_type.
module hcd_prod_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  hcd_pkg::prod_type d,
   output hcd_pkg::prod_type q
);
   hcd_pkg::prod_type prod_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         prod_ff <= d;
      end
   end

   assign q = prod_ff;
endmodule

>>> hw/rtl/hcd_response.sv
`timescale 1ns / 1ps
// Eight-stage pipeline from a 3x3 window of gradient products to a saturated
// Harris response. Uses hcd_pkg for the product and coefficient types.
module hcd_response (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic                                  in_mask,
   input  hcd_pkg::prod_type [8:0]               taps,
   input  hcd_pkg::coeff_type                    coeff,
   output logic                                  out_valid,
   output logic signed [hcd_pkg::RespBits-1:0]   out_resp
);
   localparam logic signed [44:0] RespMax = 45'sd17179869183;
   localparam logic signed [44:0] RespMin = -45'sd17179869184;

   logic [7:0] vld_ff;
   logic [7:0] msk_ff;

   logic [17:0]        cxx_ff, exx_ff, mxx_ff, cyy_ff, eyy_ff, myy_ff;
   logic signed [18:0] cxy_ff, exy_ff, mxy_ff;

   logic [33:0]        pcxx_ff, pexx_ff, pmxx_ff, pcyy_ff, peyy_ff, pmyy_ff;
   logic signed [35:0] pcxy_ff, pexy_ff, pmxy_ff;
   logic [33:0]        pcxx_in, pexx_in, pmxx_in, pcyy_in, peyy_in, pmyy_in;
   logic signed [35:0] pcxy_in, pexy_in, pmxy_in;

   logic [35:0]        accxx_in, accyy_in;
   logic signed [37:0] accxy_in;
   logic signed [20:0] sxx_ff, syy_ff, sxy_ff;

   logic signed [41:0] p1_ff, p2_ff, p1_in, p2_in;
   logic [20:0]        tr_ff;

   logic signed [42:0] det5_ff, det6_ff, det7_ff;
   logic [41:0]        trsq_ff, trsq_in;
   logic [36:0]        klo_ff, khi_ff, klo_in, khi_in;
   logic [58:0]        tsum_in;
   logic [42:0]        t_ff;
   logic signed [44:0] r_in;
   logic signed [hcd_pkg::RespBits-1:0] resp_ff, resp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      msk_ff <= {msk_ff[6:0], in_mask};
   end

   always_ff @(posedge clock) begin
      cxx_ff <= 18'(taps[0].xx) + 18'(taps[2].xx) + 18'(taps[6].xx) + 18'(taps[8].xx);
      exx_ff <= 18'(taps[1].xx) + 18'(taps[3].xx) + 18'(taps[5].xx) + 18'(taps[7].xx);
      mxx_ff <= 18'(taps[4].xx);
      cyy_ff <= 18'(taps[0].yy) + 18'(taps[2].yy) + 18'(taps[6].yy) + 18'(taps[8].yy);
      eyy_ff <= 18'(taps[1].yy) + 18'(taps[3].yy) + 18'(taps[5].yy) + 18'(taps[7].yy);
      myy_ff <= 18'(taps[4].yy);
      cxy_ff <= 19'(taps[0].xy) + 19'(taps[2].xy) + 19'(taps[6].xy) + 19'(taps[8].xy);
      exy_ff <= 19'(taps[1].xy) + 19'(taps[3].xy) + 19'(taps[5].xy) + 19'(taps[7].xy);
      mxy_ff <= 19'(taps[4].xy);
   end

   always_comb begin
      pcxx_in = cxx_ff * coeff.w_corner;
      pexx_in = exx_ff * coeff.w_edge;
      pmxx_in = mxx_ff * coeff.w_center;
      pcyy_in = cyy_ff * coeff.w_corner;
      peyy_in = eyy_ff * coeff.w_edge;
      pmyy_in = myy_ff * coeff.w_center;
      pcxy_in = cxy_ff * $signed({1'b0, coeff.w_corner});
      pexy_in = exy_ff * $signed({1'b0, coeff.w_edge});
      pmxy_in = mxy_ff * $signed({1'b0, coeff.w_center});
   end

   always_ff @(posedge clock) begin
      pcxx_ff <= pcxx_in;
      pexx_ff <= pexx_in;
      pmxx_ff <= pmxx_in;
      pcyy_ff <= pcyy_in;
      peyy_ff <= peyy_in;
      pmyy_ff <= pmyy_in;
      pcxy_ff <= pcxy_in;
      pexy_ff <= pexy_in;
      pmxy_ff <= pmxy_in;
   end

   // Rounded to nearest in Q0.16, ties upwards.
   always_comb begin
      accxx_in = 36'(pcxx_ff) + 36'(pexx_ff) + 36'(pmxx_ff) + 36'd32768;
      accyy_in = 36'(pcyy_ff) + 36'(peyy_ff) + 36'(pmyy_ff) + 36'd32768;
      accxy_in = 38'(pcxy_ff) + 38'(pexy_ff) + 38'(pmxy_ff) + 38'sd32768;
   end

   always_ff @(posedge clock) begin
      sxx_ff <= $signed({1'b0, accxx_in[35:16]});
      syy_ff <= $signed({1'b0, accyy_in[35:16]});
      sxy_ff <= accxy_in[36:16];
   end

   always_comb begin
      p1_in = 42'(sxx_ff) * 42'(syy_ff);
      p2_in = 42'(sxy_ff) * 42'(sxy_ff);
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      tr_ff <= 21'(sxx_ff[19:0]) + 21'(syy_ff[19:0]);
   end

   assign trsq_in = 42'(tr_ff) * 42'(tr_ff);

   always_ff @(posedge clock) begin
      det5_ff <= 43'(p1_ff) - 43'(p2_ff);
      trsq_ff <= trsq_in;
   end

   always_comb begin
      klo_in = 37'(coeff.k) * 37'(trsq_ff[20:0]);
      khi_in = 37'(coeff.k) * 37'(trsq_ff[41:21]);
   end

   always_ff @(posedge clock) begin
      det6_ff <= det5_ff;
      klo_ff  <= klo_in;
      khi_ff  <= khi_in;
   end

   assign tsum_in = 59'({khi_ff, 21'd0}) + 59'(klo_ff) + 59'd32768;

   always_ff @(posedge clock) begin
      det7_ff <= det6_ff;
      t_ff    <= tsum_in[58:16];
   end

   always_comb begin
      r_in = 45'(det7_ff) - $signed({2'b00, t_ff});
      if (!msk_ff[6]) begin
         resp_in = '0;
      end else if (r_in > RespMax) begin
         resp_in = RespMax[hcd_pkg::RespBits-1:0];
      end else if (r_in < RespMin) begin
         resp_in = RespMin[hcd_pkg::RespBits-1:0];
      end else begin
         resp_in = r_in[hcd_pkg::RespBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      resp_ff <= resp_in;
   end

   assign out_valid = vld_ff[7];
   assign out_resp  = resp_ff;
endmodule

>>> hw/rtl/harris_corner_detector_core.sv
`timescale 1ns / 1ps
// Top level of the 3x3 Harris corner detector.
// Uses hcd_pkg, hcd_req_if, hcd_rsp_if, hcd_history, hcd_pix_cell, hcd_prod_cell
// and hcd_response.
//
// Requests are pixels or flushes in raster order; the result for a pixel
// leaves 3*width+3 requests later, so flush requests push the last ones out.
// The block works on one request at a time. A request whose delayed slot
// holds no pixel passes through the check state back to idle. For a request
// that yields a result, the 7x7 neighbourhood of the reported pixel is read from
// the history memory one pixel a cycle, streamed
// through a chain of pixel cells that forms gradients and a chain of product
// cells that forms the 3x3 smoothing windows, and then through an
// eight-stage response pipeline. A finished result waits in the output
// register while the next request is taken. The history memory needs no
// clearing after reset; a fill count masks slots not yet written.
// Configuration is written through csr_we, csr_index and csr_wdata.
module harris_corner_detector_core (
   input  logic                            clock,
   input  logic                            reset,
   hcd_req_if.sink                         req_chan,
   hcd_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [hcd_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [hcd_pkg::CsrDataBits-1:0] csr_wdata
);
   localparam int AW = hcd_pkg::AddrBits;

   logic [10:0] width_ff;
   logic [11:0] height_ff;
   logic [15:0] wcorner_ff, wedge_ff, wcenter_ff, k_ff;
   logic [31:0] thr_ff;

   logic [10:0] eff_w;
   logic [11:0] eff_h;
   logic [11:0] ctr_age;

   hcd_pkg::state_type state_ff, state_in;
   logic accept, load_en, load_init, load_last, emit_fire, center_ok;

   logic [AW-1:0] wp_ff, wp_in, fill_ff;
   logic [AW-1:0] rd_addr;
   logic [8:0]    rd_data;
   logic [8:0]    wr_data;

   logic [11:0] pos_row_ff;
   logic [9:0]  pos_col_ff;
   logic [7:0]  center_pix_ff;

   logic [AW-1:0] ld_addr_ff, ld_age_ff;
   logic [2:0]    ly_ff, lx_ff;
   logic          issue_mask;

   logic       rd_vld_ff, rd_mask_ff;
   logic [2:0] rd_ly_ff, rd_lx_ff;

   logic [7:0]         pix_q [0:14];
   logic signed [8:0]  gx, gy;
   logic signed [17:0] gxx, gyy, gxy;
   logic               grad_ok, grad_mask;

   logic                    prod_vld_ff;
   logic [2:0]              prod_r_ff, prod_c_ff;
   hcd_pkg::prod_type       prod_ff;
   hcd_pkg::prod_type       prod_q [0:12];
   hcd_pkg::prod_type [8:0] taps;
   logic                    win_vld, win_mask;
   hcd_pkg::coeff_type      coeff;

   logic                                resp_vld;
   logic signed [hcd_pkg::RespBits-1:0] resp_val;
   logic signed [hcd_pkg::RespBits-1:0] rq_ff [0:8];
   logic [3:0]                          collect_ff;

   logic        is_corner;
   logic        frame_last;
   logic [10:0] col_next;
   logic [12:0] row_next;

   logic                                rsp_vld_ff;
   logic [7:0]                          rsp_pix_ff;
   logic                                rsp_corner_ff, rsp_last_ff;
   logic signed [hcd_pkg::RespBits-1:0] rsp_resp_ff;
   logic [9:0]                          rsp_col_ff;
   logic [11:0]                         rsp_row_ff;

   function automatic logic in_frame(input logic [11:0] row, input logic [9:0] col,
                                     input logic signed [3:0] dr,
                                     input logic signed [3:0] dc,
                                     input logic [11:0] h, input logic [10:0] w);
      logic signed [13:0] r;
      logic signed [12:0] c;
      r = $signed({2'b00, row}) + $signed({{10{dr[3]}}, dr});
      c = $signed({3'b000, col}) + $signed({{9{dc[3]}}, dc});
      return (r >= 14'sd0) && (r < $signed({2'b00, h})) &&
             (c >= 13'sd0) && (c < $signed({2'b00, w}));
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 11'd640;
         height_ff  <= 12'd480;
         wcorner_ff <= 16'd4922;
         wedge_ff   <= 16'd8116;
         wcenter_ff <= 16'd13381;
         k_ff       <= 16'd2621;
         thr_ff     <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            hcd_pkg::REG_IMAGE_WIDTH:   width_ff   <= csr_wdata[10:0];
            hcd_pkg::REG_IMAGE_HEIGHT:  height_ff  <= csr_wdata[11:0];
            hcd_pkg::REG_WEIGHT_CORNER: wcorner_ff <= csr_wdata[15:0];
            hcd_pkg::REG_WEIGHT_EDGE:   wedge_ff   <= csr_wdata[15:0];
            hcd_pkg::REG_WEIGHT_CENTER: wcenter_ff <= csr_wdata[15:0];
            hcd_pkg::REG_HARRIS_K:      k_ff       <= csr_wdata[15:0];
            hcd_pkg::REG_THRESHOLD:     thr_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < 11'd3) begin
         eff_w = 11'd3;
      end else if (width_ff > 11'(hcd_pkg::MaxWidth)) begin
         eff_w = 11'(hcd_pkg::MaxWidth);
      end else begin
         eff_w = width_ff;
      end
      eff_h   = (height_ff < 12'd3) ? 12'd3 : height_ff;
      ctr_age = {eff_w, 1'b0} + 12'(eff_w) + 12'd3;
   end

   assign coeff = '{w_corner: wcorner_ff, w_edge: wedge_ff, w_center: wcenter_ff, k: k_ff};

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcd_pkg::ST_IDLE:  if (accept) state_in = hcd_pkg::ST_CHECK;
         hcd_pkg::ST_CHECK: state_in = center_ok ? hcd_pkg::ST_LOAD : hcd_pkg::ST_IDLE;
         hcd_pkg::ST_LOAD:  if (load_last) state_in = hcd_pkg::ST_DRAIN;
         hcd_pkg::ST_DRAIN: if (collect_ff == 4'd9) state_in = hcd_pkg::ST_EMIT;
         hcd_pkg::ST_EMIT:  if (emit_fire) state_in = hcd_pkg::ST_IDLE;
         default:           state_in = hcd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == hcd_pkg::ST_IDLE);
      load_init      = (state_ff == hcd_pkg::ST_CHECK);
      load_en        = (state_ff == hcd_pkg::ST_LOAD);
      emit_fire      = (state_ff == hcd_pkg::ST_EMIT) && (!rsp_vld_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // History memory and its write pointer.
   assign accept    = req_chan.valid && req_chan.ready;
   assign wp_in     = wp_ff + 1'b1;
   assign wr_data   = req_chan.cmd ? 9'd0 : {1'b1, req_chan.pixel};
   assign rd_addr   = load_en ? ld_addr_ff : (wp_in - AW'(ctr_age));
   assign center_ok = rd_data[8] && (AW'(ctr_age) < fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         wp_ff <= wp_in;
         if (fill_ff != '1) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   hcd_history u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_in),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Neighbourhood read, 7x7 pixels in raster order.
   assign load_last  = (ly_ff == 3'd6) && (lx_ff == 3'd6);
   assign issue_mask = in_frame(pos_row_ff, pos_col_ff, $signed({1'b0, ly_ff}) - 4'sd3,
                                $signed({1'b0, lx_ff}) - 4'sd3, eff_h, eff_w) &&
                       (ld_age_ff < fill_ff);

   always_ff @(posedge clock) begin
      if (load_init) begin
         ld_addr_ff    <= wp_ff - AW'({ctr_age, 1'b0});
         ld_age_ff     <= AW'({ctr_age, 1'b0});
         ly_ff         <= '0;
         lx_ff         <= '0;
         center_pix_ff <= rd_data[7:0];
      end else if (load_en) begin
         if (lx_ff == 3'd6) begin
            lx_ff      <= '0;
            ly_ff      <= ly_ff + 1'b1;
            ld_addr_ff <= ld_addr_ff + AW'(eff_w) - AW'(6);
            ld_age_ff  <= ld_age_ff - AW'(eff_w) + AW'(6);
         end else begin
            lx_ff      <= lx_ff + 1'b1;
            ld_addr_ff <= ld_addr_ff + 1'b1;
            ld_age_ff  <= ld_age_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= load_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_mask_ff <= issue_mask;
      rd_ly_ff   <= ly_ff;
      rd_lx_ff   <= lx_ff;
   end

   // Pixel chain: cell j holds the pixel read j pixels before the incoming one.
   assign pix_q[0] = rd_mask_ff ? rd_data[7:0] : 8'd0;

   for (genvar j = 1; j <= 14; j++) begin : g_pix_chain
      hcd_pix_cell u_cell (
         .clock    (clock),
         .shift_en (rd_vld_ff),
         .d        (pix_q[j-1]),
         .q        (pix_q[j])
      );
   end

   always_comb begin
      gx        = $signed({1'b0, pix_q[6]}) - $signed({1'b0, pix_q[8]});
      gy        = $signed({1'b0, pix_q[0]}) - $signed({1'b0, pix_q[14]});
      gxx       = 18'(gx) * 18'(gx);
      gyy       = 18'(gy) * 18'(gy);
      gxy       = 18'(gx) * 18'(gy);
      grad_ok   = rd_vld_ff && (rd_ly_ff >= 3'd2) && (rd_lx_ff >= 3'd1) && (rd_lx_ff <= 3'd5);
      grad_mask = in_frame(pos_row_ff, pos_col_ff, $signed({1'b0, rd_ly_ff}) - 4'sd4,
                           $signed({1'b0, rd_lx_ff}) - 4'sd3, eff_h, eff_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= grad_ok;
      end
   end

   always_ff @(posedge clock) begin
      prod_r_ff  <= rd_ly_ff - 3'd2;
      prod_c_ff  <= rd_lx_ff - 3'd1;
      prod_ff.xx <= grad_mask ? gxx[15:0] : 16'd0;
      prod_ff.yy <= grad_mask ? gyy[15:0] : 16'd0;
      prod_ff.xy <= grad_mask ? gxy[16:0] : 17'sd0;
   end

   // Product chain over the 5x5 gradient positions.
   assign prod_q[0] = prod_ff;

   for (genvar j = 1; j <= 12; j++) begin : g_prod_chain
      hcd_prod_cell u_cell (
         .clock    (clock),
         .shift_en (prod_vld_ff),
         .d        (prod_q[j-1]),
         .q        (prod_q[j])
      );
   end

   always_comb begin
      taps[0]  = prod_q[12];
      taps[1]  = prod_q[11];
      taps[2]  = prod_q[10];
      taps[3]  = prod_q[7];
      taps[4]  = prod_q[6];
      taps[5]  = prod_q[5];
      taps[6]  = prod_q[2];
      taps[7]  = prod_q[1];
      taps[8]  = prod_q[0];
      win_vld  = prod_vld_ff && (prod_r_ff >= 3'd2) && (prod_c_ff >= 3'd2);
      win_mask = in_frame(pos_row_ff, pos_col_ff, $signed({1'b0, prod_r_ff}) - 4'sd3,
                          $signed({1'b0, prod_c_ff}) - 4'sd3, eff_h, eff_w);
   end

   hcd_response u_response (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_vld),
      .in_mask   (win_mask),
      .taps      (taps),
      .coeff     (coeff),
      .out_valid (resp_vld),
      .out_resp  (resp_val)
   );

   // The nine responses arrive in raster order; the centre ends in place four.
   always_ff @(posedge clock) begin
      if (resp_vld) begin
         rq_ff[0] <= resp_val;
         for (int i = 1; i < 9; i++) begin
            rq_ff[i] <= rq_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collect_ff <= '0;
      end else if (load_init) begin
         collect_ff <= '0;
      end else if (resp_vld) begin
         collect_ff <= collect_ff + 1'b1;
      end
   end

   always_comb begin
      is_corner = $signed({rq_ff[4][hcd_pkg::RespBits-1], rq_ff[4]}) >
                  $signed({4'b0000, thr_ff});
      for (int i = 0; i < 9; i++) begin
         if (i != 4 && !(rq_ff[4] > rq_ff[i])) begin
            is_corner = 1'b0;
         end
      end
      frame_last = (pos_row_ff == eff_h - 1'b1) && ({1'b0, pos_col_ff} == eff_w - 1'b1);
      col_next   = {1'b0, pos_col_ff} + 1'b1;
      row_next   = {1'b0, pos_row_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_row_ff <= '0;
         pos_col_ff <= '0;
      end else if (emit_fire) begin
         if (col_next >= eff_w) begin
            pos_col_ff <= '0;
            pos_row_ff <= (row_next >= {1'b0, eff_h}) ? 12'd0 : row_next[11:0];
         end else begin
            pos_col_ff <= col_next[9:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_pix_ff    <= center_pix_ff;
         rsp_corner_ff <= is_corner;
         rsp_resp_ff   <= rq_ff[4];
         rsp_col_ff    <= pos_col_ff;
         rsp_row_ff    <= pos_row_ff;
         rsp_last_ff   <= frame_last;
      end
   end

   always_comb begin
      rsp_chan.valid      = rsp_vld_ff;
      rsp_chan.pixel_out  = rsp_pix_ff;
      rsp_chan.is_corner  = rsp_corner_ff;
      rsp_chan.response   = rsp_resp_ff;
      rsp_chan.out_col    = rsp_col_ff;
      rsp_chan.out_row    = rsp_row_ff;
      rsp_chan.frame_last = rsp_last_ff;
   end
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of harris_corner_detector_core: pixel and flush requests
// are checked against a predictor of the 3x3 Harris response and corner test.
// Depends on hcd_pkg, hcd_req_if, hcd_rsp_if and the RTL of the core.
module tb;
   localparam int HistLen = 6 * hcd_pkg::MaxWidth + 7;
   localparam int MaxHeight = 4095;
   localparam longint RespHigh = 64'sd17179869183;
   localparam longint RespLow = -64'sd17179869184;
   localparam int CycleLimit = 3000000;
   localparam int DrainCycles = 120;
   localparam logic [hcd_pkg::CsrIdxBits-1:0] REG_UNUSED = 3'd7;
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic cmd;
      logic [7:0] pixel;
   } request_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic is_corner;
      logic [34:0] response;
      logic [9:0] out_col;
      logic [11:0] out_row;
      logic frame_last;
   } corner_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [hcd_pkg::CsrIdxBits-1:0] csr_index = '0;
   logic [hcd_pkg::CsrDataBits-1:0] csr_wdata = '0;

   hcd_req_if req_if();
   hcd_rsp_if rsp_if();

   harris_corner_detector_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   int unsigned img_width, img_height, w_corner, w_edge, w_center, k_factor;
   int unsigned threshold;
   logic [8:0] pixel_history [HistLen];
   int newest, row_pos, col_pos, eff_w, eff_h, centre_age;

   request_type pending_requests[$];
   corner_result_type expected_results[$];
   int error_count = 0;
   int result_count = 0;
   int corner_count = 0;
   int request_count = 0;
   longint cycle_count = 0;

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d", result_count, field, got,
               want);
      error_count++;
   endtask

   function automatic int pixel_at(int dy, int dx);
      int y, x, age;
      y = row_pos + dy;
      x = col_pos + dx;
      if (y < 0 || y >= eff_h || x < 0 || x >= eff_w) return 0;
      age = centre_age - (dy * eff_w + dx);
      return pixel_history[(newest + HistLen - age) % HistLen][7:0];
   endfunction

   function automatic longint round_q16(longint s);
      return (s + 32768) >>> 16;
   endfunction

   function automatic bit outside(int dy, int dx);
      return row_pos + dy < 0 || row_pos + dy >= eff_h || col_pos + dx < 0 ||
             col_pos + dx >= eff_w;
   endfunction

   function automatic longint harris_response(int dy, int dx);
      longint axx, ayy, axy, sxx, syy, sxy, gx, gy, wt, det, tr, r;
      longint unsigned tsq;
      int y, x, d;
      axx = 0;
      ayy = 0;
      axy = 0;
      if (outside(dy, dx)) return 0;
      for (int i = -1; i <= 1; i++) begin
         for (int j = -1; j <= 1; j++) begin
            y = dy + i;
            x = dx + j;
            d = (i != 0) + (j != 0);
            if (!outside(y, x)) begin
               gx = pixel_at(y, x + 1) - pixel_at(y, x - 1);
               gy = pixel_at(y + 1, x) - pixel_at(y - 1, x);
               wt = d == 0 ? w_center : (d == 1 ? w_edge : w_corner);
               axx += wt * gx * gx;
               ayy += wt * gy * gy;
               axy += wt * gx * gy;
            end
         end
      end
      sxx = round_q16(axx);
      syy = round_q16(ayy);
      sxy = round_q16(axy);
      det = sxx * syy - sxy * sxy;
      tr = sxx + syy;
      tsq = (longint'(k_factor) * tr * tr + 32768) >> 16;
      r = det - longint'(tsq);
      if (r > RespHigh) r = RespHigh;
      if (r < RespLow) r = RespLow;
      return r;
   endfunction

   task automatic predict_request(request_type rq);
      logic [8:0] centre;
      longint r;
      bit corner;
      corner_result_type res;
      eff_w = img_width < 3 ? 3 :
              (img_width > hcd_pkg::MaxWidth ? hcd_pkg::MaxWidth : img_width);
      eff_h = img_height < 3 ? 3 : (img_height > MaxHeight ? MaxHeight : img_height);
      centre_age = 3 * eff_w + 3;
      newest = (newest + 1) % HistLen;
      pixel_history[newest] = rq.cmd == CMD_FLUSH ? 9'd0 : {1'b1, rq.pixel};
      centre = pixel_history[(newest + HistLen - centre_age) % HistLen];
      if (!centre[8]) return;
      r = harris_response(0, 0);
      corner = r > longint'(threshold);
      for (int i = -1; i <= 1; i++)
         for (int j = -1; j <= 1; j++)
            if ((i != 0 || j != 0) && corner && !(r > harris_response(i, j))) corner = 0;
      res.pixel_out = centre[7:0];
      res.is_corner = corner;
      res.response = r[34:0];
      res.out_col = col_pos[9:0];
      res.out_row = row_pos[11:0];
      res.frame_last = row_pos == eff_h - 1 && col_pos == eff_w - 1;
      expected_results.push_back(res);
      col_pos++;
      if (col_pos >= eff_w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= eff_h) row_pos = 0;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.cmd <= CMD_PIXEL;
         req_if.pixel <= '0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_if.valid) begin
            predict_request(pending_requests.pop_front());
            request_count++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.cmd <= pending_requests[0].cmd;
            req_if.pixel <= pending_requests[0].pixel;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern whose mode is redrawn at random from three modes, plus one long hold-off.
   int stall_mode = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int accepted_rsp = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) accepted_rsp++;
         if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
         if (!hold_done && accepted_rsp == 150) begin
            hold_done = 1;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_mode == 0) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_mode == 1) begin
            rsp_if.ready <= $urandom_range(0, 3) != 0;
         end else begin
            rsp_if.ready <= $urandom_range(0, 4) == 0;
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            corner_result_type want;
            want = expected_results.pop_front();
            if (rsp_if.pixel_out !== want.pixel_out)
               report_mismatch("pixel_out", rsp_if.pixel_out, want.pixel_out);
            if (rsp_if.is_corner !== want.is_corner)
               report_mismatch("is_corner", rsp_if.is_corner, want.is_corner);
            if (rsp_if.response !== want.response)
               report_mismatch("response", rsp_if.response, $signed(want.response));
            if (rsp_if.out_col !== want.out_col)
               report_mismatch("out_col", rsp_if.out_col, want.out_col);
            if (rsp_if.out_row !== want.out_row)
               report_mismatch("out_row", rsp_if.out_row, want.out_row);
            if (rsp_if.frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_if.frame_last, want.frame_last);
            if (want.is_corner) corner_count++;
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(logic [hcd_pkg::CsrIdxBits-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         hcd_pkg::REG_IMAGE_WIDTH: img_width = value & 32'h7FF;
         hcd_pkg::REG_IMAGE_HEIGHT: img_height = value & 32'hFFF;
         hcd_pkg::REG_WEIGHT_CORNER: w_corner = value & 32'hFFFF;
         hcd_pkg::REG_WEIGHT_EDGE: w_edge = value & 32'hFFFF;
         hcd_pkg::REG_WEIGHT_CENTER: w_center = value & 32'hFFFF;
         hcd_pkg::REG_HARRIS_K: k_factor = value & 32'hFFFF;
         hcd_pkg::REG_THRESHOLD: threshold = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(int unsigned wd, int unsigned ht, int unsigned wc,
                             int unsigned we, int unsigned wm, int unsigned kf,
                             int unsigned th);
      write_reg(hcd_pkg::REG_IMAGE_WIDTH, wd);
      write_reg(hcd_pkg::REG_IMAGE_HEIGHT, ht);
      write_reg(hcd_pkg::REG_WEIGHT_CORNER, wc);
      write_reg(hcd_pkg::REG_WEIGHT_EDGE, we);
      write_reg(hcd_pkg::REG_WEIGHT_CENTER, wm);
      write_reg(hcd_pkg::REG_HARRIS_K, kf);
      write_reg(hcd_pkg::REG_THRESHOLD, th);
   endtask

   function automatic int clamped_width();
      return img_width < 3 ? 3 :
             (img_width > hcd_pkg::MaxWidth ? hcd_pkg::MaxWidth : img_width);
   endfunction

   task automatic push_flushes();
      request_type rq;
      for (int i = 0; i < 3 * clamped_width() + 3; i++) begin
         rq.cmd = CMD_FLUSH;
         rq.pixel = $urandom_range(0, 255);
         pending_requests.push_back(rq);
      end
   endtask

   // Frames of pixels with random content and the odd flush inside a frame.
   task automatic push_random(int count, int contrast);
      request_type rq;
      for (int i = 0; i < count; i++) begin
         rq.cmd = ($urandom_range(0, 19) == 0) ? CMD_FLUSH : CMD_PIXEL;
         if (contrast != 0 && $urandom_range(0, 1) == 0)
            rq.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else
            rq.pixel = $urandom_range(0, 255);
         pending_requests.push_back(rq);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   request_type directed_rows[] = '{
      '{CMD_PIXEL, 8'h00}, '{CMD_PIXEL, 8'hFF}, '{CMD_PIXEL, 8'h00}, '{CMD_PIXEL, 8'hFF},
      '{CMD_PIXEL, 8'hAA}, '{CMD_PIXEL, 8'h55}, '{CMD_FLUSH, 8'hFF}, '{CMD_PIXEL, 8'h80},
      '{CMD_PIXEL, 8'h01}, '{CMD_FLUSH, 8'h00}, '{CMD_PIXEL, 8'hFF}, '{CMD_PIXEL, 8'hFF},
      '{CMD_PIXEL, 8'h7F}, '{CMD_PIXEL, 8'hFE}, '{CMD_PIXEL, 8'h00}, '{CMD_PIXEL, 8'h10},
      '{CMD_PIXEL, 8'hFF}, '{CMD_PIXEL, 8'h00}, '{CMD_PIXEL, 8'hFF}, '{CMD_PIXEL, 8'h00}
   };

   initial begin
      img_width = 640;
      img_height = 480;
      w_corner = 4922;
      w_edge = 8116;
      w_center = 13381;
      k_factor = 2621;
      threshold = 0;
      newest = 0;
      row_pos = 0;
      col_pos = 0;
      foreach (pixel_history[i]) pixel_history[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Weights, k, threshold and height as after reset, on a narrow image.
      write_reg(hcd_pkg::REG_IMAGE_WIDTH, 8);
      foreach (directed_rows[i]) pending_requests.push_back(directed_rows[i]);
      push_random(40, 1);
      push_flushes();
      wait_idle();
      set_config(3, 3, 65535, 65535, 65535, 0, 0);
      foreach (directed_rows[i]) pending_requests.push_back(directed_rows[i]);
      push_random(200, 1);
      push_flushes();
      wait_idle();
      set_config(5, 4, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 65535, 32'hFFFFFFFF);
      write_reg(REG_UNUSED, 32'hFFFFFFFF);
      push_random(200, 0);
      push_flushes();
      wait_idle();
      set_config(0, 4095, 0, 0, 0, 0, 0);
      push_random(150, 1);
      push_flushes();
      wait_idle();
      set_config(32'h0000F828, 5, 65535, 0, 65535, 1000, 1);
      push_random(150, 1);
      push_flushes();
      wait_idle();
      set_config(8, 6, 4922, 8116, 13381, 2621, $urandom_range(0, 100000));
      push_random(250, 1);
      push_flushes();
      wait_idle();

      $display("requests accepted: %0d, results checked: %0d, corners seen: %0d",
               request_count, result_count, corner_count);
      $display("widths 3 to 40 with masking and low clamping, heights 3 to 4095, extreme weights");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
